/* sv/tdf_pkg.sv */
package tdf_pkg;

  localparam int PLANES = 4;
  localparam int ROWS   = 8;
  localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);

  // One tile: [plane][row][pixel bit], bit 7 of a row byte is the leftmost pixel
  typedef logic [PLANES-1:0][ROWS-1:0][7:0] tile_t;

  // Per-cycle commands from the controller to the datapath
  typedef struct packed {
    logic       row_we;
    logic [2:0] row_pos;
    logic       rd_en;
    logic       wr_en;
    logic       out_load;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [3:0] hit;      // bit 0 as given, 1 x mirror, 2 y mirror, 3 both
    logic       out_free;
  } sts_t;

  // Result item fields
  typedef struct packed {
    logic       table_full;
    logic       newly_added;
    logic       mirror_y;
    logic       mirror_x;
    logic [7:0] tile_index;
  } res_t;

  // Mirror left-right: reverse the pixel bits of every row byte
  function automatic tile_t mirror_cols(tile_t t);
    tile_t m;
    for (int p = 0; p < PLANES; p++) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int k = 0; k < 8; k++) begin
          m[p][r][k] = t[p][r][7-k];
        end
      end
    end
    return m;
  endfunction

  // Mirror top-bottom: reverse the row order
  function automatic tile_t mirror_rows(tile_t t);
    tile_t m;
    for (int p = 0; p < PLANES; p++) begin
      for (int r = 0; r < ROWS; r++) begin
        m[p][r] = t[p][ROWS-1-r];
      end
    end
    return m;
  endfunction

endpackage

/* sv/tdf_dpath.sv */
module tdf_dpath #(
  parameter int MAX_TILES = 256,
  parameter int IW        = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  tdf_pkg::ctl_t  ctl,
  input  logic [IW-1:0]  rd_addr,
  input  logic [IW-1:0]  wr_addr,
  input  tdf_pkg::res_t  res,
  output tdf_pkg::sts_t  sts,
  input  logic [31:0]    s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [15:0]    m_axis_tdata
);

  tdf_pkg::tile_t cur_tile;
  tdf_pkg::tile_t mem [MAX_TILES];
  tdf_pkg::tile_t rdata;
  tdf_pkg::tile_t var_x;
  tdf_pkg::tile_t var_y;
  tdf_pkg::tile_t var_xy;

  // Collect rows of the incoming tile
  always_ff @(posedge clk) begin
    if (ctl.row_we) begin
      for (int p = 0; p < tdf_pkg::PLANES; p++) begin
        cur_tile[p][ctl.row_pos] <= s_axis_tdata[8*p +: 8];
      end
    end
  end

  // Tile store: append on a miss, read one entry per cycle during the search
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= cur_tile;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Compare the stored entry against all four orientations at once
  always_comb begin
    var_x  = tdf_pkg::mirror_cols(cur_tile);
    var_y  = tdf_pkg::mirror_rows(cur_tile);
    var_xy = tdf_pkg::mirror_rows(var_x);
    sts.hit[0]   = (rdata == cur_tile);
    sts.hit[1]   = (rdata == var_x);
    sts.hit[2]   = (rdata == var_y);
    sts.hit[3]   = (rdata == var_xy);
    sts.out_free = !m_axis_tvalid || m_axis_tready;
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (ctl.out_load) begin
      m_axis_tdata <= {4'b0000, res};
    end
  end

endmodule

/* sv/tdf_ctrl.sv */
module tdf_ctrl #(
  parameter int MAX_TILES = 256,
  parameter int IW        = 8,
  parameter int CW        = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  tdf_pkg::sts_t  sts,
  output tdf_pkg::ctl_t  ctl,
  output logic [IW-1:0]  rd_addr,
  output logic [IW-1:0]  wr_addr,
  output tdf_pkg::res_t  res
);

  typedef enum logic [1:0] {S_ROWS, S_SEARCH, S_PUT} state_t;

  state_t        state;
  logic [2:0]    row_pos;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_idx;
  logic          cmp_valid;
  logic [IW-1:0] cmp_idx;
  logic          accept;
  logic          more;
  logic          full;
  logic          hit_any;
  logic [IW+7:0] hit_ext;
  logic [CW+7:0] cnt_ext;

  // Decode handshakes and search status
  always_comb begin
    accept        = s_axis_tvalid && (state == S_ROWS);
    s_axis_tready = (state == S_ROWS);
    more          = (rd_idx < cnt);
    full          = (cnt == CW'(MAX_TILES));
    hit_any       = |sts.hit;
    hit_ext       = {8'h00, cmp_idx};
    cnt_ext       = {8'h00, cnt};
    ctl.row_we    = accept;
    ctl.row_pos   = row_pos;
    ctl.rd_en     = (state == S_SEARCH) && more;
    ctl.wr_en     = (state == S_SEARCH) && !cmp_valid && !more && !full;
    ctl.out_load  = (state == S_PUT) && sts.out_free;
    rd_addr       = rd_idx[IW-1:0];
    wr_addr       = cnt[IW-1:0];
  end

  // Sequence rows, search, and result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ROWS;
      row_pos   <= 3'd0;
      cnt       <= '0;
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_ROWS: begin
          if (accept) begin
            row_pos <= row_pos + 3'd1;
            if (row_pos == tdf_pkg::LAST_ROW) begin
              state     <= S_SEARCH;
              rd_idx    <= '0;
              cmp_valid <= 1'b0;
            end
          end
        end
        S_SEARCH: begin
          // advance the read pointer; the compare follows in the next cycle
          cmp_valid <= more;
          if (more) begin
            rd_idx  <= rd_idx + CW'(1);
            cmp_idx <= rd_idx[IW-1:0];
          end
          if (cmp_valid && hit_any) begin
            res.tile_index  <= hit_ext[7:0];
            res.mirror_x    <= !sts.hit[0] && (sts.hit[1] || (!sts.hit[2] && sts.hit[3]));
            res.mirror_y    <= !sts.hit[0] && !sts.hit[1];
            res.newly_added <= 1'b0;
            res.table_full  <= 1'b0;
            state           <= S_PUT;
          end else if (!cmp_valid && !more) begin
            if (full) begin
              res.tile_index  <= 8'h00;
              res.newly_added <= 1'b0;
              res.table_full  <= 1'b1;
            end else begin
              res.tile_index  <= cnt_ext[7:0];
              res.newly_added <= 1'b1;
              res.table_full  <= 1'b0;
              cnt             <= cnt + CW'(1);
            end
            res.mirror_x <= 1'b0;
            res.mirror_y <= 1'b0;
            state        <= S_PUT;
          end
        end
        S_PUT: begin
          if (sts.out_free) begin
            state <= S_ROWS;
          end
        end
        default: begin
          state <= S_ROWS;
        end
      endcase
    end
  end

endmodule

/* sv/tile_dedup_with_flips.sv */
// Tile deduplicator with mirror matching. Each input item is one row of an
// 8x8 4-bit planar tile; rows are taken one per cycle while no search or
// result hand-off is under way. After the eighth row the block stops taking
// rows and walks the tile store through its single read port, one stored
// entry per cycle, testing each entry against the tile as given, its x
// mirror, its y mirror and both mirrors (first hit in that order wins). The
// search ends at the first hit or after the last stored tile, and the result
// is then handed to the output register once that register is free. A miss
// appends the tile; a miss with a full store reports table_full with no
// write. The output register holds one finished result, so rows of the next
// tile are taken while it waits. The store has no reset clearing: entries
// beyond the fill count are never read.
module tile_dedup_with_flips #(
  parameter int MAX_TILES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // plane0_row, plane1_row, plane2_row, plane3_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // tile_index[7:0], mirror_x, mirror_y,
                                      // newly_added, table_full, zero pad
);

  localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);

  tdf_pkg::ctl_t ctl;
  tdf_pkg::sts_t sts;
  tdf_pkg::res_t res;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  tdf_ctrl #(
    .MAX_TILES (MAX_TILES),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .res           (res)
  );

  tdf_dpath #(
    .MAX_TILES (MAX_TILES),
    .IW        (IW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .res           (res),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
